@@ design/stable_severity_priority_queue_assert.svh @@
// assertion macros used by the queue top level
// expects clk and rst_n in the scope where a macro is used
`ifndef STABLE_SEVERITY_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_SEVERITY_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SSQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SSQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ssq_pkg.sv @@
// types, codes and constants of the severity priority queue
// no dependencies
`timescale 1ns / 1ps

package ssq_pkg;

    localparam int SEV_BITS   = 3;
    localparam int AGE_BITS   = 8;
    localparam int TAG_BITS   = 16;
    localparam int STAT_BITS  = 2;
    localparam int POS_BITS   = 6;
    localparam int CFG_BITS   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 32;
    localparam int IN_PAD_W   = IN_DATA_W - TAG_BITS - AGE_BITS - SEV_BITS;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - STAT_BITS - 2 * POS_BITS - TAG_BITS
                                - AGE_BITS - SEV_BITS;

    typedef logic [SEV_BITS-1:0] sev_t;
    typedef logic [AGE_BITS-1:0] age_t;
    typedef logic [TAG_BITS-1:0] tag_t;

    localparam sev_t SEV_MIN    = 3'd1;
    localparam sev_t SEV_MAX    = 3'd5;
    localparam sev_t SEV_CHILD  = 3'd1;
    localparam sev_t SEV_SENIOR = 3'd2;
    localparam sev_t SEV_ADULT  = 3'd4;

    localparam age_t CHILD_LIMIT_RST  = 8'd12;
    localparam age_t SENIOR_LIMIT_RST = 8'd65;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [STAT_BITS-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_BAD_SEV = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHILD_LIMIT  = 2'd0,
        CFG_SENIOR_LIMIT = 2'd1,
        CFG_REASSIGN     = 2'd2
    } cfg_index_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // contents of one queue cell
    typedef struct packed {
        logic valid;
        sev_t sev;
        age_t age;
        tag_t tag;
    } entry_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic ins;
        logic rem;
        sev_t req_sev;
        sev_t sev;
        age_t age;
        tag_t tag;
    } cell_ctl_t;

endpackage

@@ design/stable_severity_priority_queue.sv @@
// channel   dir  signals                         payload
// s_axis    in   tvalid tready tdata tuser       tuser: cmd; tdata: tag, age, severity
// m_axis    out  tvalid tready tdata             tdata: status, position, count, tag,
//                                                       age, severity
// cfg       in   cfg_we cfg_index cfg_data       child limit, senior limit, reassign
//
// an item is captured and its severity resolved against all cells in ST_IDLE, then the row
// of cells shifts in parallel in ST_EXEC; a held result stalls the shift in ST_EXEC
// a new item is taken while the previous result still waits in the output register
// reset clears the cell valid bits and the count and loads the default limits at once; no clearing pass
// top level of the severity priority queue; depends on ssq_pkg, ssq_cell and
// stable_severity_priority_queue_assert.svh
`timescale 1ns / 1ps

module stable_severity_priority_queue
    import ssq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // patient_tag, age, severity, pad
    input  logic                  s_axis_tuser,  // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // status, position, entry_count,
                                                 // out_tag, out_age, out_severity, pad
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data
);

`include "stable_severity_priority_queue_assert.svh"

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    age_t             child_reg;
    age_t             senior_reg;
    logic             reassign_reg;
    logic             out_valid_reg;
    logic             out_valid_next;

    cmd_t    cmd_reg;
    status_t status_reg;
    status_t status_next;
    sev_t    sev_reg;
    sev_t    sev_next;
    age_t    age_reg;
    tag_t    tag_reg;

    status_t          out_status_reg;
    status_t          out_status_next;
    logic [POS_BITS-1:0] out_pos_reg;
    logic [POS_BITS-1:0] out_pos_next;
    logic [POS_BITS-1:0] out_count_reg;
    logic [POS_BITS-1:0] out_count_next;
    tag_t             out_tag_reg;
    tag_t             out_tag_next;
    age_t             out_age_reg;
    age_t             out_age_next;
    sev_t             out_sev_reg;
    sev_t             out_sev_next;

    logic             accept;
    logic             go;
    cmd_t             in_cmd;
    tag_t             in_tag;
    age_t             in_age;
    sev_t             in_sev;
    logic             repeated;
    logic [IDX_W-1:0] pos_idx;
    logic [CNT_W-1:0] pos_val;
    cell_ctl_t        ctl;

    entry_t                 ent      [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] keep_vec;
    logic [QUEUE_DEPTH-1:0] here_vec;
    logic [QUEUE_DEPTH-1:0] match_vec;
    logic [QUEUE_DEPTH-1:0] valid_vec;

    assign in_cmd = cmd_t'(s_axis_tuser);
    assign in_tag = s_axis_tdata[TAG_BITS-1:0];
    assign in_age = s_axis_tdata[TAG_BITS +: AGE_BITS];
    assign in_sev = s_axis_tdata[TAG_BITS + AGE_BITS +: SEV_BITS];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {OUT_PAD_W'(0), out_sev_reg, out_age_reg, out_tag_reg,
                            out_count_reg, out_pos_reg, out_status_reg};

    // ---------------- row of cells ----------------
    assign ctl = '{ins: go && (cmd_reg == CMD_INSERT) && (status_reg == STAT_OK),
                   rem: go && (cmd_reg == CMD_REMOVE) && (status_reg == STAT_OK),
                   req_sev: in_sev, sev: sev_reg, age: age_reg, tag: tag_reg};

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_ent;
        entry_t right_ent;
        logic   left_keep;

        if (i == 0)
        begin : g_head
            assign left_ent  = '0;
            assign left_keep = 1'b1;
        end
        else
        begin : g_body
            assign left_ent  = ent[i-1];
            assign left_keep = keep_vec[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_ent = '0;
        end
        else
        begin : g_inner
            assign right_ent = ent[i+1];
        end

        ssq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .left_ent  (left_ent),
            .left_keep (left_keep),
            .right_ent (right_ent),
            .ent       (ent[i]),
            .keep      (keep_vec[i]),
            .here      (here_vec[i]),
            .match     (match_vec[i])
        );

        assign valid_vec[i] = ent[i].valid;
    end

    assign repeated = |match_vec;

    // the insert point is one-hot, so the index is an or of the set positions
    always_comb
    begin
        pos_idx = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (here_vec[i])
            begin
                pos_idx = pos_idx | IDX_W'(i);
            end
        end
    end

    assign pos_val = CNT_W'(pos_idx) + CNT_W'(1);

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        go            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_EXEC:
            begin
                go = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // status and severity are settled when the item is taken
    always_comb
    begin
        status_next = STAT_OK;
        sev_next    = in_sev;
        if (in_cmd == CMD_REMOVE)
        begin
            if (count_reg == '0)
            begin
                status_next = STAT_EMPTY;
            end
        end
        else if (!(in_sev inside {[SEV_MIN:SEV_MAX]}))
        begin
            status_next = STAT_BAD_SEV;
        end
        else if (count_reg >= DEPTH_CNT)
        begin
            status_next = STAT_FULL;
        end
        if (reassign_reg && repeated)
        begin
            if (in_age < child_reg)
            begin
                sev_next = SEV_CHILD;
            end
            else if (in_age > senior_reg)
            begin
                sev_next = SEV_SENIOR;
            end
            else
            begin
                sev_next = SEV_ADULT;
            end
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        out_status_next = status_reg;
        out_pos_next    = '0;
        out_tag_next    = '0;
        out_age_next    = '0;
        out_sev_next    = '0;
        if (status_reg == STAT_OK)
        begin
            if (cmd_reg == CMD_REMOVE)
            begin
                count_next   = count_reg - CNT_W'(1);
                out_tag_next = ent[0].tag;
                out_age_next = ent[0].age;
                out_sev_next = ent[0].sev;
            end
            else
            begin
                count_next   = count_reg + CNT_W'(1);
                out_pos_next = POS_BITS'(pos_val);
                out_tag_next = tag_reg;
                out_age_next = age_reg;
                out_sev_next = sev_reg;
            end
        end
        out_count_next = POS_BITS'(count_next);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            child_reg     <= CHILD_LIMIT_RST;
            senior_reg    <= SENIOR_LIMIT_RST;
            reassign_reg  <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (go)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHILD_LIMIT:  child_reg    <= cfg_data;
                    CFG_SENIOR_LIMIT: senior_reg   <= cfg_data;
                    CFG_REASSIGN:     reassign_reg <= cfg_data[0];
                    default:          reassign_reg <= reassign_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= in_cmd;
            status_reg <= status_next;
            sev_reg    <= sev_next;
            age_reg    <= in_age;
            tag_reg    <= in_tag;
        end
        if (go)
        begin
            out_status_reg <= out_status_next;
            out_pos_reg    <= out_pos_next;
            out_count_reg  <= out_count_next;
            out_tag_reg    <= out_tag_next;
            out_age_reg    <= out_age_next;
            out_sev_reg    <= out_sev_next;
        end
    end

    // ---------------- checks ----------------
    `SSQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= DEPTH_CNT, "entry count above depth")
    `SSQ_ASSERT_IMP(a_valid_count, 1'b1, $countones(valid_vec) == count_reg, "valid count off")
    `SSQ_ASSERT_IMP(a_one_insert_point, ctl.ins, $onehot(here_vec), "insert point not unique")
    `SSQ_ASSERT_NXT(a_result_follows, go, out_valid_reg && state_reg == ST_IDLE, "result missing")
    `SSQ_ASSERT_IMP(a_remove_has_head, ctl.rem, ent[0].valid, "remove without a head entry")

endmodule

@@ design/ssq_cell.sv @@
// one slot of the sorted queue: holds an entry and shifts with its neighbors
// depends on ssq_pkg
`timescale 1ns / 1ps

module ssq_cell
    import ssq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  entry_t    left_ent,
    input  logic      left_keep,
    input  entry_t    right_ent,
    output entry_t    ent,
    output logic      keep,
    output logic      here,
    output logic      match
);

    logic valid_reg;
    logic valid_next;
    sev_t sev_reg;
    sev_t sev_next;
    age_t age_reg;
    age_t age_next;
    tag_t tag_reg;
    tag_t tag_next;

    assign ent   = '{valid: valid_reg, sev: sev_reg, age: age_reg, tag: tag_reg};
    assign match = valid_reg && (sev_reg == ctl.req_sev);
    // entries of lower or equal severity stay ahead of the new one
    assign keep  = valid_reg && (sev_reg <= ctl.sev);
    assign here  = left_keep && !keep;

    always_comb
    begin
        valid_next = valid_reg;
        sev_next   = sev_reg;
        age_next   = age_reg;
        tag_next   = tag_reg;
        if (ctl.rem)
        begin
            valid_next = right_ent.valid;
            sev_next   = right_ent.sev;
            age_next   = right_ent.age;
            tag_next   = right_ent.tag;
        end
        else if (ctl.ins && !keep)
        begin
            if (left_keep)
            begin
                valid_next = 1'b1;
                sev_next   = ctl.sev;
                age_next   = ctl.age;
                tag_next   = ctl.tag;
            end
            else
            begin
                valid_next = left_ent.valid;
                sev_next   = left_ent.sev;
                age_next   = left_ent.age;
                tag_next   = left_ent.tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sev_reg <= sev_next;
        age_reg <= age_next;
        tag_reg <= tag_next;
    end

endmodule
